### design/sbc_pkg.sv
// Shared constants and helper functions for the segment versus box collision test.
package sbc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned NUM_FACES       = 6;
  localparam int unsigned NUM_BOX_REGS    = 6;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned FACE_WIDTH      = 3;

  localparam logic [FACE_WIDTH-1:0] FACE_ZMIN = 3'd0;
  localparam logic [FACE_WIDTH-1:0] FACE_YMIN = 3'd1;
  localparam logic [FACE_WIDTH-1:0] FACE_XMAX = 3'd2;
  localparam logic [FACE_WIDTH-1:0] FACE_YMAX = 3'd3;
  localparam logic [FACE_WIDTH-1:0] FACE_XMIN = 3'd4;
  localparam logic [FACE_WIDTH-1:0] FACE_ZMAX = 3'd5;
  localparam logic [FACE_WIDTH-1:0] FACE_NONE = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Normal axis of each face, in test order.
  function automatic logic [1:0] face_axis(input int unsigned f);
    logic [1:0] ax;
    unique case (f)
      0, 5:    ax = AXIS_Z;
      1, 3:    ax = AXIS_Y;
      default: ax = AXIS_X;
    endcase
    return ax;
  endfunction

  // Whether a face lies on the upper bound of its axis.
  function automatic logic face_upper(input int unsigned f);
    logic up;
    unique case (f)
      2, 3, 5: up = 1'b1;
      default: up = 1'b0;
    endcase
    return up;
  endfunction

  // The two axes other than k, lower one first.
  function automatic logic [1:0] other_axis(input logic [1:0] k, input logic m);
    logic [1:0] ax;
    if (!m) begin
      ax = (k == AXIS_X) ? AXIS_Y : AXIS_X;
    end else begin
      ax = (k == AXIS_Z) ? AXIS_Y : AXIS_Z;
    end
    return ax;
  endfunction

endpackage

### design/sbc_seg_if.sv
// Valid/ready channel that carries one segment as two 3-D endpoints.
interface sbc_seg_if #(
  parameter int unsigned COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

### design/sbc_res_if.sv
// Valid/ready channel that carries one collision result.
interface sbc_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] hit_face;

  modport source (output valid, hit, hit_face, input ready);
  modport sink (input valid, hit, hit_face, output ready);
endinterface

### design/segment_box_collision_test.sv
// Segment versus axis-aligned box collision test, four-stage pipeline.
//
// A segment arrives on seg_i as two endpoints in signed fixed point. The box
// bounds are six registers written through cfg_we_i, cfg_idx_i and cfg_data_i,
// index 0 to 5 as x min, x max, y min, y max, z min, z max; other indexes are
// ignored. Write them only while no item is in flight.
// For each item one result leaves on res_o: hit and the first face that the
// segment crosses, in the order z min, y min, x max, y max, x min, z max, or
// face code 6 when there is no hit.
// One item can enter every cycle while the receiver does not stall. The face
// test avoids division: the quotient range check is turned into products, and
// the multipliers of stage three set the cycle time.
// Reset clears all stage valid bits and the box registers to zero.
// When the receiver stalls, each stage holds until the stage after it frees,
// so empty stages still fill and nothing is lost or repeated.
module segment_box_collision_test
  import sbc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]   cfg_data_i,
  sbc_seg_if.sink                  seg_i,
  sbc_res_if.source                res_o
);

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned P = 2 * W + 4;

  typedef logic signed [W-1:0] coord_t;
  typedef logic signed [W:0]   diff_t;
  typedef logic signed [W+1:0] num_t;
  typedef logic signed [P-1:0] prod_t;

  typedef struct packed {
    diff_t lo_off;
    diff_t hi_off;
    diff_t eo;
  } prep_ax_t;

  typedef struct packed {
    logic       skip;
    logic       k_ok;
    logic [W:0] den;
    num_t       num;
    prep_ax_t [1:0] ax;
  } prep_t;

  typedef struct packed {
    prod_t x;
    prod_t lo_d;
    prod_t hi_d;
    logic  lo_pos;
    logic  hi_neg;
  } prod_ax_t;

  typedef struct packed {
    logic       skip;
    logic       k_ok;
    logic [W:0] den;
    prod_ax_t [1:0] ax;
  } prod_face_t;

  // Box registers.
  coord_t box_q [NUM_BOX_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BOX_REGS; i++) box_q[i] <= '0;
    end else if (cfg_we_i && cfg_idx_i < CFG_IDX_WIDTH'(NUM_BOX_REGS)) begin
      box_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic en1, en2, en3, en_out;

  assign en_out      = !out_v_q || res_o.ready;
  assign en3         = !s3_v_q || en_out;
  assign en2         = !s2_v_q || en3;
  assign en1         = !s1_v_q || en2;
  assign seg_i.ready = en1;

  // Stage 1: capture endpoints.
  coord_t a_q [3];
  coord_t b_q [3];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a_q[0] <= seg_i.start_x;
      a_q[1] <= seg_i.start_y;
      a_q[2] <= seg_i.start_z;
      b_q[0] <= seg_i.end_x;
      b_q[1] <= seg_i.end_y;
      b_q[2] <= seg_i.end_z;
    end
  end

  // Stage 2 prep: per face, the plane offset, the divisor and the allowed
  // quotient interval on each other axis, relative to the start point.
  prep_t prep_d [NUM_FACES];
  prep_t prep_q [NUM_FACES];

  always_comb begin
    diff_t      e [3];
    coord_t     lo [3];
    coord_t     hi [3];
    coord_t     smin [3];
    coord_t     smax [3];
    logic [1:0] k;
    logic [1:0] o;
    coord_t     c;
    diff_t      num;
    logic       flat;
    coord_t     lim_lo;
    coord_t     lim_hi;
    for (int j = 0; j < 3; j++) begin
      e[j]    = diff_t'(a_q[j]) - diff_t'(b_q[j]);
      lo[j]   = box_q[2*j];
      hi[j]   = box_q[2*j+1];
      smin[j] = (a_q[j] < b_q[j]) ? a_q[j] : b_q[j];
      smax[j] = (a_q[j] < b_q[j]) ? b_q[j] : a_q[j];
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      k    = face_axis(f);
      c    = face_upper(f) ? hi[k] : lo[k];
      num  = diff_t'(c) - diff_t'(a_q[k]);
      flat = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (2'(j) != k && hi[j] == lo[j]) flat = 1'b1;
      end
      prep_d[f].skip = flat || (e[k] == '0);
      prep_d[f].k_ok = (c >= lo[k]) && (c <= hi[k]) && (c >= smin[k]) && (c <= smax[k]);
      prep_d[f].den  = e[k][W] ? $unsigned(-e[k]) : $unsigned(e[k]);
      // Folding the divisor's sign into the numerator leaves a positive divisor.
      prep_d[f].num  = e[k][W] ? -num_t'(num) : num_t'(num);
      for (int m = 0; m < 2; m++) begin
        o      = other_axis(k, m[0]);
        lim_lo = (lo[o] > smin[o]) ? lo[o] : smin[o];
        lim_hi = (hi[o] < smax[o]) ? hi[o] : smax[o];
        prep_d[f].ax[m].lo_off = diff_t'(lim_lo) - diff_t'(a_q[o]);
        prep_d[f].ax[m].hi_off = diff_t'(lim_hi) - diff_t'(a_q[o]);
        prep_d[f].ax[m].eo     = e[o];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int f = 0; f < NUM_FACES; f++) prep_q[f] <= prep_d[f];
    end
  end

  // Stage 3: products for the exact quotient range check.
  prod_face_t prod_d [NUM_FACES];
  prod_face_t prod_q [NUM_FACES];

  always_comb begin
    prod_t den_p;
    prod_t num_p;
    for (int f = 0; f < NUM_FACES; f++) begin
      den_p = prod_t'({1'b0, prep_q[f].den});
      num_p = prod_t'(prep_q[f].num);
      prod_d[f].skip = prep_q[f].skip;
      prod_d[f].k_ok = prep_q[f].k_ok;
      prod_d[f].den  = prep_q[f].den;
      for (int m = 0; m < 2; m++) begin
        prod_d[f].ax[m].x      = num_p * prod_t'(prep_q[f].ax[m].eo);
        prod_d[f].ax[m].lo_d   = prod_t'(prep_q[f].ax[m].lo_off) * den_p;
        prod_d[f].ax[m].hi_d   = prod_t'(prep_q[f].ax[m].hi_off) * den_p;
        prod_d[f].ax[m].lo_pos = !prep_q[f].ax[m].lo_off[W] && (prep_q[f].ax[m].lo_off != '0);
        prod_d[f].ax[m].hi_neg = prep_q[f].ax[m].hi_off[W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int f = 0; f < NUM_FACES; f++) prod_q[f] <= prod_d[f];
    end
  end

  // Output stage: the truncated quotient t lies in [L, U] exactly when the
  // numerator X meets these bounds against multiples of the divisor D:
  // t >= L is X >= L*D for positive L, else X > L*D - D;
  // t <= U is X <= U*D for negative U, else X < U*D + D.
  logic [NUM_FACES-1:0] face_ok;
  logic                 hit_d;
  logic [2:0]           face_d;

  always_comb begin
    prod_t den_p;
    logic  ok;
    for (int f = 0; f < NUM_FACES; f++) begin
      den_p = prod_t'({1'b0, prod_q[f].den});
      ok    = !prod_q[f].skip && prod_q[f].k_ok;
      for (int m = 0; m < 2; m++) begin
        if (prod_q[f].ax[m].lo_pos) begin
          if (prod_q[f].ax[m].x < prod_q[f].ax[m].lo_d) ok = 1'b0;
        end else begin
          if (prod_q[f].ax[m].x <= prod_q[f].ax[m].lo_d - den_p) ok = 1'b0;
        end
        if (prod_q[f].ax[m].hi_neg) begin
          if (prod_q[f].ax[m].x > prod_q[f].ax[m].hi_d) ok = 1'b0;
        end else begin
          if (prod_q[f].ax[m].x >= prod_q[f].ax[m].hi_d + den_p) ok = 1'b0;
        end
      end
      face_ok[f] = ok;
    end
    hit_d  = 1'b0;
    face_d = FACE_NONE;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (face_ok[f]) begin
        hit_d  = 1'b1;
        face_d = 3'(f);
      end
    end
  end

  logic       hit_q;
  logic [2:0] face_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q  <= hit_d;
      face_q <= face_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    s1_v_q  <= seg_i.valid;
      if (en2)    s2_v_q  <= s1_v_q;
      if (en3)    s3_v_q  <= s2_v_q;
      if (en_out) out_v_q <= s3_v_q;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.hit      = hit_q;
  assign res_o.hit_face = face_q;

endmodule

### bench/tb_segment_box_collision_test.sv
// Self-checking testbench for the segment versus box collision test.
module tb_segment_box_collision_test
  import sbc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BOX_X_MIN = 0;
  localparam int BOX_X_MAX = 1;
  localparam int BOX_Y_MIN = 2;
  localparam int BOX_Y_MAX = 3;
  localparam int BOX_Z_MIN = 4;
  localparam int BOX_Z_MAX = 5;
  localparam int INT_MIN = -2147483647 - 1;
  localparam int INT_MAX = 2147483647;

  // Faces in test order, with the normal axis and the bound each one sits on.
  localparam logic [2:0] FACE_ORDER [6] = '{FACE_ZMIN, FACE_YMIN, FACE_XMAX,
                                           FACE_YMAX, FACE_XMIN, FACE_ZMAX};
  localparam int FACE_NORMAL [6] = '{2, 1, 0, 1, 0, 2};
  localparam bit FACE_ON_MAX [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  typedef struct {
    int a [3];
    int b [3];
  } segment_t;

  typedef struct {
    logic       hit;
    logic [2:0] face;
  } collision_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  sbc_seg_if seg_if ();
  sbc_res_if res_if ();

  segment_box_collision_test u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .seg_i      (seg_if.sink),
    .res_o      (res_if.source)
  );

  int         box_shadow [6];
  collision_t expected_hits [$];
  bit         idle_on;
  int         errors;
  int         quiet_cycles;
  int         stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic collision_t predict_collision(segment_t s);
    longint a [3], e [3], lo [3], hi [3], smin [3], smax [3], p [3];
    longint c, num, qs;
    logic [127:0] prod, quo;
    int k;
    bit ok, flat, neg;
    collision_t r;
    r.hit  = 1'b0;
    r.face = FACE_NONE;
    for (int j = 0; j < 3; j++) begin
      a[j]    = s.a[j];
      e[j]    = longint'(s.a[j]) - longint'(s.b[j]);
      lo[j]   = box_shadow[2*j];
      hi[j]   = box_shadow[2*j+1];
      smin[j] = (s.a[j] < s.b[j]) ? s.a[j] : s.b[j];
      smax[j] = (s.a[j] < s.b[j]) ? s.b[j] : s.a[j];
    end
    for (int f = 0; f < 6; f++) begin
      k    = FACE_NORMAL[f];
      c    = FACE_ON_MAX[f] ? hi[k] : lo[k];
      num  = c - a[k];
      ok   = 1'b1;
      flat = 1'b0;
      for (int j = 0; j < 3; j++)
        if (j != k && hi[j] == lo[j]) flat = 1'b1;
      if (flat || e[k] == 0) continue;
      for (int j = 0; j < 3; j++) begin
        if (j == k) begin
          p[j] = c;
        end else begin
          neg  = ((num < 0) != (e[j] < 0)) != (e[k] < 0);
          prod = 128'(magnitude(num)) * 128'(magnitude(e[j]));
          quo  = prod / 128'(magnitude(e[k]));
          // Far-off points are capped; they miss every box anyway.
          if (quo > (128'(1) << 62)) quo = 128'(1) << 62;
          qs   = longint'(quo[63:0]);
          p[j] = a[j] + (neg ? -qs : qs);
        end
        if (p[j] < lo[j] || p[j] > hi[j] || p[j] < smin[j] || p[j] > smax[j]) ok = 1'b0;
      end
      if (ok) begin
        r.hit  = 1'b1;
        r.face = FACE_ORDER[f];
        return r;
      end
    end
    return r;
  endfunction

  // Sink side: random stall bursts while idling is on.
  initial begin
    res_if.ready = 1'b1;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 14);
      if (!idle_on) stall_left = 0;
      res_if.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Accepted segments are predicted, accepted results are checked.
  always @(posedge clk_i) begin
    collision_t got, want;
    if (rst_ni) begin
      if (seg_if.valid && seg_if.ready) begin
        segment_t s;
        s.a = '{seg_if.start_x, seg_if.start_y, seg_if.start_z};
        s.b = '{seg_if.end_x, seg_if.end_y, seg_if.end_z};
        expected_hits.push_back(predict_collision(s));
      end
      if (res_if.valid && res_if.ready) begin
        got.hit  = res_if.hit;
        got.face = res_if.hit_face;
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result hit=%0b face=%0d", $time, got.hit, got.face);
          errors++;
        end else begin
          want = expected_hits.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, got.hit);
            errors++;
          end
          if (got.face !== want.face) begin
            $display("%0t: hit_face mismatch expected %0d actual %0d",
                     $time, want.face, got.face);
            errors++;
          end
        end
      end
      if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else if (seg_if.valid || expected_hits.size() != 0)
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[segment_box_collision_test] ERROR");
        $finish;
      end
    end
  end

  task automatic send_segment(segment_t s);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      seg_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    seg_if.valid   = 1'b1;
    seg_if.start_x = s.a[0];
    seg_if.start_y = s.a[1];
    seg_if.start_z = s.a[2];
    seg_if.end_x   = s.b[0];
    seg_if.end_y   = s.b[1];
    seg_if.end_z   = s.b[2];
    do @(posedge clk_i); while (!seg_if.ready);
  endtask

  // Stop sending and let the pipeline empty, including its four stages.
  task automatic drain_pipeline();
    @(negedge clk_i);
    seg_if.valid = 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(int idx, int value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx[CFG_IDX_WIDTH-1:0];
    cfg_data_i = value;
    if (idx < 6) box_shadow[idx] = value;
  endtask

  task automatic load_box(int xl, int xh, int yl, int yh, int zl, int zh);
    write_reg(BOX_X_MIN, xl);
    write_reg(BOX_X_MAX, xh);
    write_reg(BOX_Y_MIN, yl);
    write_reg(BOX_Y_MAX, yh);
    write_reg(BOX_Z_MIN, zl);
    write_reg(BOX_Z_MAX, zh);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic segment_t make_segment(int ax, int ay, int az, int bx, int by, int bz);
    segment_t s;
    s.a = '{ax, ay, az};
    s.b = '{bx, by, bz};
    return s;
  endfunction

  function automatic int clamp_coord(longint v);
    if (v < INT_MIN) return INT_MIN;
    if (v > INT_MAX) return INT_MAX;
    return int'(v);
  endfunction

  // A coordinate near the box on one axis: bounds, around them, or anywhere.
  function automatic int near_coord(int axis);
    longint lo, hi, span;
    lo   = box_shadow[2*axis];
    hi   = box_shadow[2*axis+1];
    span = magnitude(hi - lo) + 1;
    case ($urandom_range(0, 9))
      0: return int'(lo);
      1: return int'(hi);
      2: return int'($urandom);
      default: return clamp_coord(((lo < hi) ? lo : hi) - span +
                                  longint'($urandom) % (3 * span + 1));
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    if ($urandom_range(0, 6) == 0) begin
      for (int j = 0; j < 3; j++) begin
        s.a[j] = $urandom;
        s.b[j] = $urandom;
      end
    end else begin
      for (int j = 0; j < 3; j++) begin
        s.a[j] = near_coord(j);
        s.b[j] = near_coord(j);
        // Segments parallel to a face pair.
        if ($urandom_range(0, 7) == 0) s.b[j] = s.a[j];
      end
    end
    return s;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_segment(random_segment());
  endtask

  task automatic load_random_box();
    int c [3], h [3];
    for (int j = 0; j < 3; j++) begin
      c[j] = $urandom_range(0, 2 << 20) - (1 << 20);
      h[j] = $urandom_range(1, 1 << 18);
    end
    load_box(c[0] - h[0], c[0] + h[0], c[1] - h[1], c[1] + h[1], c[2] - h[2], c[2] + h[2]);
  endtask

  // Reset box is all zero, so every face is flat and nothing can hit.
  task automatic test_reset_box();
    send_segment(make_segment(-5, -5, -5, 5, 5, 5));
    send_random(20);
    drain_pipeline();
  endtask

  task automatic test_directed();
    load_box(-100, 100, -100, 100, -100, 100);
    send_segment(make_segment(0, 0, -200, 0, 0, 0));
    send_segment(make_segment(0, -200, 0, 0, 0, 0));
    send_segment(make_segment(200, 0, 0, 0, 0, 0));
    send_segment(make_segment(0, 200, 0, 0, 0, 0));
    send_segment(make_segment(-200, 0, 0, 0, 0, 0));
    send_segment(make_segment(0, 0, 200, 0, 0, 0));
    send_segment(make_segment(-10, -10, -10, 10, 10, 10));
    send_segment(make_segment(-300, 0, 0, 300, 0, 0));
    send_segment(make_segment(-300, 300, 0, 300, 300, 0));
    send_segment(make_segment(100, 100, 100, 200, 200, 200));
    send_segment(make_segment(50, 50, 50, 50, 50, 50));
    send_segment(make_segment(INT_MIN, INT_MIN, INT_MIN, INT_MAX, INT_MAX, INT_MAX));
    send_segment(make_segment(INT_MAX, INT_MIN, 0, INT_MIN, INT_MAX, 0));
    send_segment(make_segment(INT_MIN, 0, INT_MAX, INT_MAX, 1, INT_MIN));
    send_segment(make_segment(-1, -1, -1, INT_MIN, INT_MIN, INT_MIN));
    send_segment(make_segment(101, 0, 0, 100, 0, 0));
    drain_pipeline();
  endtask

  task automatic test_extreme_box();
    load_box(INT_MIN, INT_MAX, INT_MIN, INT_MAX, INT_MIN, INT_MAX);
    send_segment(make_segment(INT_MIN, 0, 0, INT_MAX, 0, 0));
    send_segment(make_segment(0, 0, INT_MIN, 0, 0, INT_MAX));
    send_segment(make_segment(INT_MAX, INT_MAX, INT_MAX, 0, 0, 0));
    send_random(60);
    drain_pipeline();
  endtask

  task automatic test_inverted_box();
    load_box(100, -100, -100, 100, -100, 100);
    send_segment(make_segment(0, 0, -200, 0, 0, 200));
    send_random(60);
    drain_pipeline();
  endtask

  task automatic test_flat_box();
    load_box(-100, 100, 0, 0, -100, 100);
    send_segment(make_segment(0, 0, -200, 0, 0, 200));
    send_segment(make_segment(0, -200, 0, 0, 200, 0));
    send_random(60);
    drain_pipeline();
  endtask

  // Indexes six and seven must leave the box untouched.
  task automatic test_ignored_index();
    load_box(-1000, 1000, -1000, 1000, -1000, 1000);
    write_reg(6, 0);
    write_reg(7, 0);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    send_segment(make_segment(0, 0, -2000, 0, 0, 0));
    send_random(40);
    drain_pipeline();
  endtask

  task automatic test_random_boxes();
    for (int b = 0; b < 8; b++) begin
      load_random_box();
      send_random(100);
      // Sender holds off until every result is back.
      drain_pipeline();
      send_random(20);
      drain_pipeline();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    load_random_box();
    send_random(150);
    drain_pipeline();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0;
    seg_if.start_y = '0;
    seg_if.start_z = '0;
    seg_if.end_x   = '0;
    seg_if.end_y   = '0;
    seg_if.end_z   = '0;
    idle_on        = 1'b1;
    errors         = 0;
    quiet_cycles   = 0;
    box_shadow     = '{0, 0, 0, 0, 0, 0};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_box();
    test_directed();
    test_extreme_box();
    test_inverted_box();
    test_flat_box();
    test_ignored_index();
    test_random_boxes();
    test_full_rate();
    repeat (10) @(negedge clk_i);
    if (expected_hits.size() != 0) begin
      $display("%0t: %0d results missing", $time, expected_hits.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[segment_box_collision_test] OK");
    end else begin
      $display("[segment_box_collision_test] ERROR");
    end
    $finish;
  end

endmodule
